>>> rtl/assert_macros.svh
// Assertion helpers shared by the deque RTL.
// Every check is sampled on the rising clock edge and is off while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every edge.
`define DEQ_CHECK(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define DEQ_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define DEQ_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared opcodes, field widths and the control/status bundles that pass
// between the deque controller and the deque datapath.
// ----------------------------------------------------------------------------
package deq_pkg;

	// Fixed port field widths
	localparam int OP_W    = 2;
	localparam int DATA_W  = 32;
	localparam int COUNT_W = 5;

	// Request opcodes
	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd0;
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 2'd1;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 2'd2;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 2'd3;

	// Commands from controller to datapath, one request at a time
	typedef struct packed {
		logic take;        // a request is accepted this cycle
		logic push_front;
		logic push_back;
		logic pop_front;
		logic pop_back;
		logic empty_hit;   // pop refused, queue empty
		logic full_hit;    // push refused, queue full
	} deq_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic empty;
		logic full;
	} deq_status_t;

endpackage

>>> rtl/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram
// Generic single-port RAM with a registered read port. A read updates the
// output register only when enabled without a write, so the data holds
// until the next read.
// ----------------------------------------------------------------------------
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read
	always_ff @(posedge clk) begin
		if (en && we) begin
			mem_q[addr] <= wdata;
		end
		if (en && !we) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl
// Deque controller: decodes each accepted request against the queue status
// into datapath commands and sequences the one-cycle result strobe.
// ----------------------------------------------------------------------------
module deq_ctrl
	import deq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [OP_W-1:0]       opcode,
	input  deq_status_t           status,
	output deq_cmd_t              cmd,
	output logic                  busy,
	output logic                  done
);

	localparam logic ST_IDLE   = 1'b0;
	localparam logic ST_RESULT = 1'b1;

	logic state_q;
	logic state_d;
	logic accept;

	// The store takes one access per request, so requests never stall
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Request decode against current occupancy
	always_comb begin
		cmd      = '0;
		cmd.take = accept;
		if (accept) begin
			case (opcode)
				OP_PUSH_FRONT: begin
					cmd.full_hit   = status.full;
					cmd.push_front = !status.full;
				end
				OP_PUSH_BACK: begin
					cmd.full_hit  = status.full;
					cmd.push_back = !status.full;
				end
				OP_POP_FRONT: begin
					cmd.empty_hit = status.empty;
					cmd.pop_front = !status.empty;
				end
				OP_POP_BACK: begin
					cmd.empty_hit = status.empty;
					cmd.pop_back  = !status.empty;
				end
				default: begin
					cmd.take = 1'b0;
				end
			endcase
		end
	end

	// Result sequencing: one strobe cycle after each accepted request
	always_comb begin
		case (state_q)
			ST_IDLE:   state_d = accept ? ST_RESULT : ST_IDLE;
			ST_RESULT: state_d = accept ? ST_RESULT : ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign done = (state_q == ST_RESULT);

`include "assert_macros.svh"

	`DEQ_IMPLY(a_done_follows_req, done, $past(accept), "result strobe without a request")
	`DEQ_IMPLY(a_empty_hit_ok, cmd.empty_hit, status.empty && !cmd.full_hit, "empty flag on a non-empty queue")
	`DEQ_IMPLY(a_full_hit_ok, cmd.full_hit, status.full && !cmd.empty_hit, "full flag on a non-full queue")

endmodule

>>> rtl/deq_dp.sv
// ----------------------------------------------------------------------------
// deq_dp
// Deque datapath: ring store with front and back indices and an entry
// count, plus the result registers for one request.
// ----------------------------------------------------------------------------
module deq_dp
	import deq_pkg::*;
#(
	parameter int CAPACITY    = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  deq_cmd_t             cmd,
	input  logic [DATA_W-1:0]    push_value,
	output deq_status_t          status,
	output logic [DATA_W-1:0]    pop_value,
	output logic                 was_empty,
	output logic                 was_full,
	output logic [COUNT_W-1:0]   entry_count
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

	logic [IDX_W-1:0]       front_q;
	logic [IDX_W-1:0]       back_q;
	logic [CNT_W-1:0]       count_q;
	logic                   pop_hit_q;
	logic                   empty_q;
	logic                   full_q;

	logic [IDX_W-1:0]       front_prev;
	logic [IDX_W-1:0]       front_next;
	logic [IDX_W-1:0]       back_prev;
	logic [IDX_W-1:0]       back_next;
	logic                   ram_en;
	logic                   ram_we;
	logic [IDX_W-1:0]       ram_addr;
	logic [VALUE_WIDTH-1:0] ram_wdata;
	logic [VALUE_WIDTH-1:0] ram_rdata;
	logic [DATA_W-1:0]      rd_ext;

	// Ring neighbors of both ends
	assign front_prev = (front_q == '0) ? LAST_IDX : front_q - 1'b1;
	assign front_next = (front_q == LAST_IDX) ? '0 : front_q + 1'b1;
	assign back_prev  = (back_q == '0) ? LAST_IDX : back_q - 1'b1;
	assign back_next  = (back_q == LAST_IDX) ? '0 : back_q + 1'b1;

	assign status.empty = (count_q == '0);
	assign status.full  = (count_q == FULL_CNT);

	// Store port: one access per request
	assign ram_en = cmd.push_front || cmd.push_back || cmd.pop_front || cmd.pop_back;
	assign ram_we = cmd.push_front || cmd.push_back;

	always_comb begin
		if (cmd.push_front) begin
			ram_addr = front_prev;
		end else if (cmd.push_back) begin
			ram_addr = back_q;
		end else if (cmd.pop_back) begin
			ram_addr = back_prev;
		end else begin
			ram_addr = front_q;
		end
	end

	// Fit the push word to the stored width and the stored word to the port
	generate
		if (VALUE_WIDTH <= DATA_W) begin : g_wr_trunc
			assign ram_wdata = push_value[VALUE_WIDTH-1:0];
		end else begin : g_wr_ext
			assign ram_wdata = {{(VALUE_WIDTH-DATA_W){1'b0}}, push_value};
		end
		if (VALUE_WIDTH >= DATA_W) begin : g_rd_trunc
			assign rd_ext = ram_rdata[DATA_W-1:0];
		end else begin : g_rd_ext
			assign rd_ext = {{(DATA_W-VALUE_WIDTH){1'b0}}, ram_rdata};
		end
		if (CNT_W >= COUNT_W) begin : g_cnt_trunc
			assign entry_count = count_q[COUNT_W-1:0];
		end else begin : g_cnt_ext
			assign entry_count = {{(COUNT_W-CNT_W){1'b0}}, count_q};
		end
	endgenerate

	deq_ram #(
		.WIDTH (VALUE_WIDTH),
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// Index and count update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q  <= '0;
			count_q <= '0;
		end else begin
			if (cmd.push_front) begin
				front_q <= front_prev;
			end else if (cmd.pop_front) begin
				front_q <= front_next;
			end
			if (cmd.push_back) begin
				back_q <= back_next;
			end else if (cmd.pop_back) begin
				back_q <= back_prev;
			end
			if (cmd.push_front || cmd.push_back) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.pop_front || cmd.pop_back) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Result flags for the request just taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop_hit_q <= 1'b0;
			empty_q   <= 1'b0;
			full_q    <= 1'b0;
		end else if (cmd.take) begin
			pop_hit_q <= cmd.pop_front || cmd.pop_back;
			empty_q   <= cmd.empty_hit;
			full_q    <= cmd.full_hit;
		end
	end

	assign pop_value = pop_hit_q ? rd_ext : '0;
	assign was_empty = empty_q;
	assign was_full  = full_q;

`include "assert_macros.svh"

	`DEQ_CHECK(a_count_bound, count_q <= FULL_CNT, "entry count above capacity")
	`DEQ_CHECK(a_flags_excl, !(empty_q && full_q) && !(pop_hit_q && (empty_q || full_q)), "conflicting result flags")
	`DEQ_NEXT(a_push_count, cmd.push_front || cmd.push_back, count_q == $past(count_q) + 1'b1, "push did not raise count")
	`DEQ_NEXT(a_ends_meet, cmd.take && !cmd.push_front && !cmd.push_back && !cmd.pop_front && !cmd.pop_back, $stable(count_q) && $stable(front_q) && $stable(back_q), "refused request changed state")

endmodule

>>> rtl/double_ended_queue.sv
// Latency: a request accepted at a clock edge has its result strobed on done in the next cycle.
// Throughput: one request per cycle; busy stays low, the single-port ring store takes one access per request.
// Reset: arst_n clears indices, count and result flags; store contents stay undefined until pushed.
// Results cannot be stalled: each is valid while done is high and holds only until the next request is taken.
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue held in a ring store. Push and pop at either
// end; pops on an empty queue and pushes on a full queue are flagged.
// ----------------------------------------------------------------------------
module double_ended_queue
	import deq_pkg::*;
#(
	parameter int CAPACITY    = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [OP_W-1:0]    opcode,
	input  logic [DATA_W-1:0]  push_value,
	output logic               done,
	output logic [DATA_W-1:0]  pop_value,
	output logic               was_empty,
	output logic               was_full,
	output logic [COUNT_W-1:0] entry_count
);

	deq_cmd_t    cmd;
	deq_status_t status;

	deq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	deq_dp #(
		.CAPACITY    (CAPACITY),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.push_value  (push_value),
		.status      (status),
		.pop_value   (pop_value),
		.was_empty   (was_empty),
		.was_full    (was_full),
		.entry_count (entry_count)
	);

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives push and pop requests into the double-ended queue and checks every
// strobed result against a ring-store predictor kept in the bench, or typed
// rows against their hand-typed result. A short directed table covers empty
// pops, extreme values, filling to full and pushes on a full queue. Random
// traffic follows; the shifting push/pop mix swings the queue empty to full.
// ----------------------------------------------------------------------------
module testbench
	import deq_pkg::*;
();

	localparam int DEPTH          = 16;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 4;

	// One result as strobed on the output ports
	typedef struct packed {
		logic [DATA_W-1:0]  pop_value;
		logic               was_empty;
		logic               was_full;
		logic [COUNT_W-1:0] entry_count;
	} deq_result_t;

	// One row of directed stimulus; typed rows carry their result by hand
	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [DATA_W-1:0] value;
		logic              typed;
		deq_result_t       res;
	} stim_row_t;

	localparam int DIRECTED_ROWS = 26;
	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		// empty pops after reset
		{OP_POP_FRONT,  32'h0000_0000, 1'b1, {32'h0000_0000, 1'b1, 1'b0, 5'd0}},
		{OP_POP_BACK,   32'hFFFF_FFFF, 1'b1, {32'h0000_0000, 1'b1, 1'b0, 5'd0}},
		// extreme values in at both ends, out at the same ends
		{OP_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1, {32'h0000_0000, 1'b0, 1'b0, 5'd1}},
		{OP_PUSH_BACK,  32'h0000_0000, 1'b1, {32'h0000_0000, 1'b0, 1'b0, 5'd2}},
		{OP_POP_BACK,   32'h1234_5678, 1'b1, {32'h0000_0000, 1'b0, 1'b0, 5'd1}},
		{OP_POP_FRONT,  32'h0000_0000, 1'b1, {32'hFFFF_FFFF, 1'b0, 1'b0, 5'd0}},
		// fill to capacity from both ends
		{OP_PUSH_FRONT, 32'h0000_0001, 1'b0, 39'd0},
		{OP_PUSH_BACK,  32'h8000_0000, 1'b0, 39'd0},
		{OP_PUSH_FRONT, 32'h5555_5555, 1'b0, 39'd0},
		{OP_PUSH_BACK,  32'hAAAA_AAAA, 1'b0, 39'd0},
		{OP_PUSH_FRONT, 32'h0F0F_0F0F, 1'b0, 39'd0},
		{OP_PUSH_BACK,  32'hF0F0_F0F0, 1'b0, 39'd0},
		{OP_PUSH_FRONT, 32'h0123_4567, 1'b0, 39'd0},
		{OP_PUSH_BACK,  32'h89AB_CDEF, 1'b0, 39'd0},
		{OP_PUSH_FRONT, 32'h00FF_00FF, 1'b0, 39'd0},
		{OP_PUSH_BACK,  32'hFF00_FF00, 1'b0, 39'd0},
		{OP_PUSH_FRONT, 32'h3333_CCCC, 1'b0, 39'd0},
		{OP_PUSH_BACK,  32'hCCCC_3333, 1'b0, 39'd0},
		{OP_PUSH_FRONT, 32'h7FFF_FFFF, 1'b0, 39'd0},
		{OP_PUSH_BACK,  32'hFFFF_FFFE, 1'b0, 39'd0},
		{OP_PUSH_FRONT, 32'h0000_FFFF, 1'b0, 39'd0},
		{OP_PUSH_BACK,  32'hFFFF_0000, 1'b0, 39'd0},
		// pushes on a full queue are dropped
		{OP_PUSH_BACK,  32'h1234_5678, 1'b1, {32'h0000_0000, 1'b0, 1'b1, 5'd16}},
		{OP_PUSH_FRONT, 32'h9ABC_DEF0, 1'b1, {32'h0000_0000, 1'b0, 1'b1, 5'd16}},
		{OP_POP_FRONT,  32'h0000_0000, 1'b0, 39'd0},
		{OP_POP_BACK,   32'h0000_0000, 1'b0, 39'd0}
	};

	logic               clk;
	logic               arst_n     = 1'b0;
	logic               start      = 1'b0;
	logic [OP_W-1:0]    opcode     = OP_PUSH_FRONT;
	logic [DATA_W-1:0]  push_value = '0;
	logic               busy;
	logic               done;
	logic [DATA_W-1:0]  pop_value;
	logic               was_empty;
	logic               was_full;
	logic [COUNT_W-1:0] entry_count;

	// predictor state
	logic [DATA_W-1:0]  ring_store [DEPTH];
	int                 ring_front = 0;
	int                 ring_back  = 0;
	int                 ring_count = 0;

	deq_result_t        expected_outcomes [$];
	int                 sender_idle_pct = 0;
	int                 fail_count      = 0;
	int                 stall_cycles    = 0;

	double_ended_queue dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.opcode      (opcode),
		.push_value  (push_value),
		.done        (done),
		.pop_value   (pop_value),
		.was_empty   (was_empty),
		.was_full    (was_full),
		.entry_count (entry_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Ring-store predictor: applies one request and returns its result
	task automatic deque_model_step(input logic [OP_W-1:0] op,
			input logic [DATA_W-1:0] value, output deq_result_t res);
		res = '0;
		case (op)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (ring_count == DEPTH) begin
					res.was_full = 1'b1;
				end else if (op == OP_PUSH_FRONT) begin
					ring_front = (ring_front == 0) ? DEPTH - 1 : ring_front - 1;
					ring_store[ring_front] = value;
					ring_count++;
				end else begin
					ring_store[ring_back] = value;
					ring_back = (ring_back == DEPTH - 1) ? 0 : ring_back + 1;
					ring_count++;
				end
			end
			default: begin
				if (ring_count == 0) begin
					res.was_empty = 1'b1;
				end else if (op == OP_POP_FRONT) begin
					res.pop_value = ring_store[ring_front];
					ring_front = (ring_front == DEPTH - 1) ? 0 : ring_front + 1;
					ring_count--;
				end else begin
					ring_back = (ring_back == 0) ? DEPTH - 1 : ring_back - 1;
					res.pop_value = ring_store[ring_back];
					ring_count--;
				end
			end
		endcase
		res.entry_count = ring_count[COUNT_W-1:0];
	endtask

	// Send one request, with random idle cycles ahead of it
	task automatic send_request(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] value,
			input logic typed, input deq_result_t typed_res);
		deq_result_t predicted;
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start      <= 1'b1;
		opcode     <= op;
		push_value <= value;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		deque_model_step(op, value, predicted);
		expected_outcomes.push_back(typed ? typed_res : predicted);
	endtask

	// Random traffic; the push share is redrawn every 40 requests
	task automatic random_traffic(input int count, input int idle_pct);
		int                push_pct;
		logic [OP_W-1:0]   op;
		logic [DATA_W-1:0] value;
		push_pct        = 50;
		sender_idle_pct = idle_pct;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0) begin
				case ($urandom_range(2))
					0:       push_pct = 15;
					1:       push_pct = 50;
					default: push_pct = 85;
				endcase
			end
			if ($urandom_range(99) < push_pct)
				op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
			else
				op = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
			case ($urandom_range(7))
				0:       value = '0;
				1:       value = '1;
				default: value = $urandom;
			endcase
			send_request(op, value, 1'b0, '0);
		end
	endtask

	// Result checker: each strobe against the oldest prediction
	always @(posedge clk) begin
		deq_result_t want;
		if (arst_n && done) begin
			if (expected_outcomes.size() == 0) begin
				$error("result strobed with no request outstanding");
				fail_count++;
			end else begin
				want = expected_outcomes.pop_front();
				if (pop_value !== want.pop_value) begin
					$error("pop_value: expected %h, got %h", want.pop_value, pop_value);
					fail_count++;
				end
				if (was_empty !== want.was_empty) begin
					$error("was_empty: expected %b, got %b", want.was_empty, was_empty);
					fail_count++;
				end
				if (was_full !== want.was_full) begin
					$error("was_full: expected %b, got %b", want.was_full, was_full);
					fail_count++;
				end
				if (entry_count !== want.entry_count) begin
					$error("entry_count: expected %0d, got %0d", want.entry_count,
						entry_count);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: too long with no request taken and no result strobed
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL double_ended_queue");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Stimulus sequence
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		sender_idle_pct = 15;
		for (int r = 0; r < DIRECTED_ROWS; r++)
			send_request(DIRECTED[r].op, DIRECTED[r].value, DIRECTED[r].typed,
				DIRECTED[r].res);

		random_traffic(520, 15);
		random_traffic(515, 81);
		random_traffic(515, 0);
		start <= 1'b0;

		while (expected_outcomes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("PASS double_ended_queue");
		else
			$display("FAIL double_ended_queue");
		$finish;
	end

endmodule

>>> double_ended_queue.f
+incdir+rtl
rtl/deq_pkg.sv
rtl/deq_ram.sv
rtl/deq_ctrl.sv
rtl/deq_dp.sv
rtl/double_ended_queue.sv
tb/testbench.sv
